// ===== rtl/hdpd_pkg.sv =====
// Package for the heading PD controller: field widths, angle constants,
// register indexes, stage structs and the angle wrap function.
// Used by every module of the block; depends on nothing.
package hdpd_pkg;

	localparam int COUNTER_WIDTH = 32;
	localparam int TOTAL_W = 32;
	localparam int ANGLE_W = 15;
	localparam int YAW_W = 16;
	localparam int RATE_W = 16;
	localparam int GAIN_W = 16;
	localparam int LIMIT_W = 17;
	localparam int BASE_W = 18;
	localparam int CORR_W = 18;
	localparam int SPEED_W = 19;
	localparam int PROD_W = 32;
	localparam int RAW_W = 26;
	localparam int P_SHIFT = 10;
	localparam int D_SHIFT = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 18;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 136;

	localparam logic signed [YAW_W-1:0] HALF_TURN = 16'sd11520;
	localparam logic signed [YAW_W-1:0] FULL_TURN = 16'sd23040;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P = 3'd0,
		REG_GAIN_D = 3'd1,
		REG_LIMIT = 3'd2,
		REG_BASE = 3'd3,
		REG_TARGET = 3'd4,
		REG_ENABLE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] kd;
		logic [LIMIT_W-1:0] limit;
		logic signed [BASE_W-1:0] base;
		logic signed [ANGLE_W-1:0] target;
		logic enable;
	} cfg_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] err;
		logic signed [PROD_W-1:0] p_prod;
		logic signed [PROD_W-1:0] d_prod;
	} err_stage_t;

	typedef struct packed {
		logic updated;
		logic signed [ANGLE_W-1:0] heading_error;
		logic signed [CORR_W-1:0] correction;
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic saturated;
		logic [COUNTER_WIDTH-1:0] saturation_total;
		logic [COUNTER_WIDTH-1:0] update_total;
	} result_t;

	// Folds an angle into the closed half turn on either side of zero; one step
	// is enough for any 16-bit input, and both ends of the half turn are kept.
	function automatic logic signed [ANGLE_W-1:0] wrap_angle(
		input logic signed [YAW_W-1:0] a
	);
		logic signed [YAW_W-1:0] w;
		begin
			if (a > HALF_TURN) begin
				w = a - FULL_TURN;
			end else if (a < -HALF_TURN) begin
				w = a + FULL_TURN;
			end else begin
				w = a;
			end
			return w[ANGLE_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/heading_pd_controller_top.sv =====
// Heading PD controller for a differential-drive base: an input register,
// two compute stages and an output register, with the configuration registers
// and the two step counters. Items pass a register between the stages;
// one item is accepted every cycle while the output is taken.
// Reset clears all configuration registers, both counters and all valid flags.
module heading_pd_controller_top
	import hdpd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// measured_yaw [15:0], yaw_rate [31:16]
	input  logic [IN_DATA_W-1:0]       s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// heading_error [14:0], correction [32:15], left_speed [51:33],
	// right_speed [70:52], saturated [71], saturation_total [103:72],
	// update_total [135:104]
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// updated [0]
	output logic                       m_axis_tuser
);

	cfg_t cfg_q;
	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic signed [YAW_W-1:0] yaw_s1;
	logic signed [RATE_W-1:0] rate_s1;
	err_stage_t err_next;
	err_stage_t err_s2;
	result_t res_next;
	result_t res_q;
	logic [COUNTER_WIDTH-1:0] sat_count_q;
	logic [COUNTER_WIDTH-1:0] upd_count_q;
	logic load_out;
	logic load_s2;
	logic load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P: cfg_q.kp <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D: cfg_q.kd <= cfg_data[GAIN_W-1:0];
				REG_LIMIT:  cfg_q.limit <= cfg_data[LIMIT_W-1:0];
				REG_BASE:   cfg_q.base <= cfg_data[BASE_W-1:0];
				REG_TARGET: cfg_q.target <= cfg_data[ANGLE_W-1:0];
				REG_ENABLE: cfg_q.enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign load_out = !out_valid_q || m_axis_tready;
	assign load_s2 = !valid_s2 || load_out;
	assign load_s1 = !valid_s1 || load_s2;
	assign s_axis_tready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (load_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && s_axis_tvalid) begin
			yaw_s1 <= s_axis_tdata[15:0];
			rate_s1 <= s_axis_tdata[31:16];
		end
		if (load_s2 && valid_s1) begin
			err_s2 <= err_next;
		end
		if (load_out && valid_s2) begin
			res_q <= res_next;
		end
	end

	hdpd_error_stage u_error (
		.cfg  (cfg_q),
		.yaw  (yaw_s1),
		.rate (rate_s1),
		.res  (err_next)
	);

	hdpd_law_stage u_law (
		.cfg       (cfg_q),
		.in_stage  (err_s2),
		.sat_count (sat_count_q),
		.upd_count (upd_count_q),
		.res       (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_count_q <= '0;
			upd_count_q <= '0;
		end else if (load_out && valid_s2 && res_next.updated) begin
			sat_count_q <= res_next.saturation_total;
			upd_count_q <= res_next.update_total;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = res_q.updated;
	assign m_axis_tdata = {
		TOTAL_W'(res_q.update_total),
		TOTAL_W'(res_q.saturation_total),
		res_q.saturated,
		res_q.right_speed,
		res_q.left_speed,
		res_q.correction,
		res_q.heading_error
	};

endmodule

// ===== rtl/hdpd_error_stage.sv =====
// First compute stage: wraps yaw and target, forms the heading error and
// both gain products. Depends on hdpd_pkg.
module hdpd_error_stage
	import hdpd_pkg::*;
(
	input  cfg_t                       cfg,
	input  logic signed [YAW_W-1:0]    yaw,
	input  logic signed [RATE_W-1:0]   rate,
	output err_stage_t                 res
);

	logic signed [ANGLE_W-1:0] yaw_w;
	logic signed [ANGLE_W-1:0] target_w;
	logic signed [YAW_W-1:0] diff;
	logic signed [ANGLE_W-1:0] err;
	logic signed [GAIN_W:0] kp_s;
	logic signed [GAIN_W:0] kd_s;

	always_comb begin
		yaw_w = wrap_angle(yaw);
		target_w = wrap_angle(YAW_W'(cfg.target));
		diff = YAW_W'(target_w) - YAW_W'(yaw_w);
		err = wrap_angle(diff);
		kp_s = {1'b0, cfg.kp};
		kd_s = {1'b0, cfg.kd};
		res.err = err;
		res.p_prod = PROD_W'(kp_s) * PROD_W'(err);
		res.d_prod = PROD_W'(kd_s) * PROD_W'(rate);
	end

endmodule

// ===== rtl/hdpd_law_stage.sv =====
// Second compute stage: scales the products, clamps the correction, forms
// the wheel speeds and the next counter values, or gives all zeros while disabled. Depends on hdpd_pkg.
module hdpd_law_stage
	import hdpd_pkg::*;
(
	input  cfg_t                        cfg,
	input  err_stage_t                  in_stage,
	input  logic [COUNTER_WIDTH-1:0]    sat_count,
	input  logic [COUNTER_WIDTH-1:0]    upd_count,
	output result_t                     res
);

	logic signed [RAW_W-1:0] p_term;
	logic signed [RAW_W-1:0] d_term;
	logic signed [RAW_W-1:0] raw;
	logic signed [RAW_W-1:0] lim;
	logic signed [RAW_W-1:0] corr_wide;
	logic sat;
	logic signed [CORR_W-1:0] corr;

	always_comb begin
		p_term = RAW_W'(in_stage.p_prod >>> P_SHIFT);
		d_term = RAW_W'(in_stage.d_prod >>> D_SHIFT);
		raw = p_term - d_term;
		lim = RAW_W'({1'b0, cfg.limit});
		sat = 1'b0;
		corr_wide = raw;
		if (raw > lim) begin
			corr_wide = lim;
			sat = 1'b1;
		end else if (raw < -lim) begin
			corr_wide = -lim;
			sat = 1'b1;
		end
		corr = corr_wide[CORR_W-1:0];

		res = '0;
		if (cfg.enable) begin
			res.updated = 1'b1;
			res.heading_error = in_stage.err;
			res.correction = corr;
			res.left_speed = SPEED_W'(cfg.base) - SPEED_W'(corr);
			res.right_speed = SPEED_W'(cfg.base) + SPEED_W'(corr);
			res.saturated = sat;
			res.saturation_total = sat ? sat_count + COUNTER_WIDTH'(1) : sat_count;
			res.update_total = upd_count + COUNTER_WIDTH'(1);
		end
	end

endmodule

// ===== tb/hdpd_checker.sv =====
// Checker for the heading PD controller: watches the configuration port and both
// streams, predicts each result from its own copy of the registers and counters,
// and compares. Depends on hdpd_pkg for widths and register indexes.
`timescale 1ns / 1ps

module hdpd_checker
	import hdpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  m_axis_tuser,
	output int                    mismatch_count,
	output int                    pending_steps
);

	typedef struct packed {
		logic                     updated;
		logic [ANGLE_W-1:0]       heading_error;
		logic [CORR_W-1:0]        correction;
		logic [SPEED_W-1:0]       left_speed;
		logic [SPEED_W-1:0]       right_speed;
		logic                     saturated;
		logic [TOTAL_W-1:0]       saturation_total;
		logic [TOTAL_W-1:0]       update_total;
	} steer_result_t;

	steer_result_t steering_due[$];

	int kp_cfg;
	int kd_cfg;
	int limit_cfg;
	int base_cfg;
	int target_cfg;
	logic run_enabled;
	logic [COUNTER_WIDTH-1:0] clamp_count;
	logic [COUNTER_WIDTH-1:0] step_count;

	function automatic int fold_angle(input int a);
		int w;
		w = a;
		while (w > 11520)
			w = w - 23040;
		while (w < -11520)
			w = w + 23040;
		return w;
	endfunction

	function automatic steer_result_t predict_steering(input logic [15:0] yaw_bits,
		input logic [15:0] rate_bits);
		steer_result_t r;
		int yaw_w;
		int err;
		longint raw;
		longint corr;
		longint left_w;
		longint right_w;
		logic clamp;
		r = '0;
		if (!run_enabled)
			return r;
		yaw_w = fold_angle(int'($signed(yaw_bits)));
		err = fold_angle(fold_angle(target_cfg) - yaw_w);
		raw = ((longint'(kp_cfg) * err) >>> P_SHIFT)
			- ((longint'(kd_cfg) * int'($signed(rate_bits))) >>> D_SHIFT);
		clamp = 1'b0;
		corr = raw;
		if (raw > limit_cfg) begin
			corr = limit_cfg;
			clamp = 1'b1;
		end else if (raw < -limit_cfg) begin
			corr = -limit_cfg;
			clamp = 1'b1;
		end
		left_w = base_cfg - corr;
		right_w = base_cfg + corr;
		if (clamp)
			clamp_count = clamp_count + COUNTER_WIDTH'(1);
		step_count = step_count + COUNTER_WIDTH'(1);
		r.updated = 1'b1;
		r.heading_error = err[ANGLE_W-1:0];
		r.correction = corr[CORR_W-1:0];
		r.left_speed = left_w[SPEED_W-1:0];
		r.right_speed = right_w[SPEED_W-1:0];
		r.saturated = clamp;
		r.saturation_total = TOTAL_W'(clamp_count);
		r.update_total = TOTAL_W'(step_count);
		return r;
	endfunction

	task automatic compare_field(input string label, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("hdpd_checker: %s expected %h, got %h at %0t",
					label, want, got, $realtime);
		end
	endtask

	task automatic compare_result(input steer_result_t want);
		compare_field("updated", 32'(want.updated), 32'(m_axis_tuser));
		compare_field("heading_error", 32'(want.heading_error),
			32'(m_axis_tdata[14:0]));
		compare_field("correction", 32'(want.correction), 32'(m_axis_tdata[32:15]));
		compare_field("left_speed", 32'(want.left_speed), 32'(m_axis_tdata[51:33]));
		compare_field("right_speed", 32'(want.right_speed), 32'(m_axis_tdata[70:52]));
		compare_field("saturated", 32'(want.saturated), 32'(m_axis_tdata[71]));
		compare_field("saturation_total", want.saturation_total, m_axis_tdata[103:72]);
		compare_field("update_total", want.update_total, m_axis_tdata[135:104]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steering_due.delete();
			mismatch_count = 0;
			kp_cfg = 0;
			kd_cfg = 0;
			limit_cfg = 0;
			base_cfg = 0;
			target_cfg = 0;
			run_enabled = 1'b0;
			clamp_count = '0;
			step_count = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN_P: kp_cfg = int'(cfg_data[GAIN_W-1:0]);
					REG_GAIN_D: kd_cfg = int'(cfg_data[GAIN_W-1:0]);
					REG_LIMIT: limit_cfg = int'(cfg_data[LIMIT_W-1:0]);
					REG_BASE: base_cfg = int'($signed(cfg_data[BASE_W-1:0]));
					REG_TARGET: target_cfg = int'($signed(cfg_data[ANGLE_W-1:0]));
					REG_ENABLE: run_enabled = cfg_data[0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (steering_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("hdpd_checker: result %h with no item pending at %0t",
							m_axis_tdata, $realtime);
				end else begin
					compare_result(steering_due.pop_front());
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				steering_due.push_back(predict_steering(s_axis_tdata[15:0],
					s_axis_tdata[31:16]));
		end
		pending_steps = steering_due.size();
	end

endmodule

// ===== tb/heading_pd_controller_top_tb.sv =====
// Testbench top for the heading PD controller: clock, reset, register writes,
// directed and random yaw items, random output stalls and the verdict.
// Depends on hdpd_pkg, heading_pd_controller_top and hdpd_checker.
`timescale 1ns / 1ps

module heading_pd_controller_top_tb;
	import hdpd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 175;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	int mismatch_count;
	int pending_steps;
	int send_calm = 0;
	int take_calm = 0;
	int cur_target = 0;

	heading_pd_controller_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	hdpd_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.mismatch_count(mismatch_count),
		.pending_steps(pending_steps)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		#4_000_000;
		$display("heading_pd_controller_top_tb: FAIL");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_settings(input int kp, input int kd, input int lim,
		input int base, input int tgt, input bit en);
		write_reg(REG_GAIN_P, kp[CFG_DATA_W-1:0]);
		write_reg(REG_GAIN_D, kd[CFG_DATA_W-1:0]);
		write_reg(REG_LIMIT, lim[CFG_DATA_W-1:0]);
		write_reg(REG_BASE, base[CFG_DATA_W-1:0]);
		write_reg(REG_TARGET, tgt[CFG_DATA_W-1:0]);
		write_reg(REG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
		cur_target = tgt;
	endtask

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_yaw(input int yaw, input int rate);
		int gap;
		bit taken;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 17);
			if ($urandom_range(0, 15) == 0)
				send_calm = $urandom_range(10, 50);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {rate[15:0], yaw[15:0]};
		s_axis_tvalid <= 1'b1;
		do begin
			@(posedge clk);
			taken = s_axis_tready;
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_steps != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_random_settings;
		int kp;
		int kd;
		int lim;
		int base;
		int tgt;
		case ($urandom_range(0, 3))
			0: kp = 0;
			1: kp = 65535;
			2: kp = $urandom_range(0, 65535);
			default: kp = $urandom_range(0, 4095);
		endcase
		case ($urandom_range(0, 3))
			0: kd = 0;
			1: kd = 65535;
			2: kd = $urandom_range(0, 65535);
			default: kd = $urandom_range(0, 1023);
		endcase
		case ($urandom_range(0, 4))
			0: lim = 0;
			1: lim = 131071;
			2: lim = $urandom_range(0, 131071);
			default: lim = $urandom_range(0, 4000);
		endcase
		case ($urandom_range(0, 4))
			0: base = -131072;
			1: base = 131071;
			default: base = int'($urandom_range(0, 262143)) - 131072;
		endcase
		if ($urandom_range(0, 1) == 0)
			tgt = int'($urandom_range(0, 32767)) - 16384;
		else
			tgt = int'($urandom_range(0, 23040)) - 11520;
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
				CFG_DATA_W'($urandom));
		load_settings(kp, kd, lim, base, tgt, $urandom_range(0, 5) != 0);
	endtask

	task automatic send_random_yaw;
		int yaw;
		int rate;
		if ($urandom_range(0, 1) == 0)
			yaw = int'($urandom_range(0, 65535)) - 32768;
		else
			yaw = cur_target + int'($urandom_range(0, 400)) - 200;
		if ($urandom_range(0, 1) == 0)
			rate = int'($urandom_range(0, 65535)) - 32768;
		else
			rate = int'($urandom_range(0, 400)) - 200;
		send_yaw(yaw, rate);
	endtask

	initial begin
		int gap;
		bit took;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (take_calm > 0) begin
				take_calm--;
				gap = 0;
			end else begin
				gap = $urandom_range(0, 17);
				if ($urandom_range(0, 15) == 0)
					take_calm = $urandom_range(10, 50);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(posedge clk);
				took = m_axis_tvalid;
				@(negedge clk);
			end while (!took);
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Unity rate gain, quarter error gain, wide limit: yaw extremes and both ends of the half turn.
		load_settings(256, 256, 131071, 1000, 0, 1'b1);
		send_yaw(0, 0);
		send_yaw(32767, 0);
		send_yaw(-32768, 0);
		send_yaw(11520, 0);
		send_yaw(-11520, 0);
		send_yaw(11521, -1);
		send_yaw(-11521, 1);
		send_yaw(0, 32767);
		send_yaw(0, -32768);
		drain();

		// Full gains and a small limit clamp the correction low; the target needs wrapping.
		load_settings(65535, 65535, 100, 131071, 16383, 1'b1);
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '1);
		send_yaw(-5000, 0);
		send_yaw(5000, 32767);
		drain();

		// Zero limit forces the correction to zero.
		load_settings(65535, 0, 0, -131072, -16384, 1'b1);
		send_yaw(0, 0);
		send_yaw(6656, 0);
		drain();

		load_settings(0, 0, 131071, -131072, 11520, 1'b1);
		send_yaw(-11520, 0);
		send_yaw(11520, 0);
		drain();

		load_settings(1234, 4321, 5000, 77, -11520, 1'b0);
		send_yaw(100, -32768);
		send_yaw(-32768, 32767);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_random_settings();
			repeat (PHASE_ITEMS) send_random_yaw();
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_steps == 0) begin
			$display("heading_pd_controller_top_tb: PASS");
		end else begin
			$display("heading_pd_controller_top_tb: FAIL");
		end
		$finish;
	end

endmodule
